// ===== src/averaging_voltmeter_with_min_max_core_macros.svh =====
// Assertion macros shared by the voltmeter RTL files.
`ifndef AVERAGING_VOLTMETER_WITH_MIN_MAX_CORE_MACROS_SVH
`define AVERAGING_VOLTMETER_WITH_MIN_MAX_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define AVMM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("avmm: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define AVMM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("avmm: next-cycle check failed");

`endif

// ===== src/avmm_pkg.sv =====
// Types, constants and small helper functions of the averaging voltmeter.
`timescale 1ns / 1ps
`default_nettype none

package avmm_pkg;

  localparam int SAMPLES_PER_AVERAGE = 8;
  localparam logic [5:0] FULL_SCALE = 6'd33;
  localparam logic [15:0] REPORT_PERIOD_RESET = 16'd100;

  // (s*33 + 511) / 1023 as one multiply by a reciprocal:
  // q = (s*33*R + 511*R) >> 26 with R = ceil(2^26 / 1023) = 65601.
  // Error stays below 1/1023 over the whole sample range, so q is exact.
  localparam int SCALE_SHIFT = 26;
  localparam logic [31:0] SCALE_MULT = 32'd2164833;
  localparam logic [31:0] SCALE_ADD = 32'd33522111;

  // Batch average divides by a reciprocal too.
  localparam int DIV_SHIFT = 20;

  // Register map (index = paddr[2]).
  localparam logic REG_REPORT_PERIOD = 1'b0;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_TICK     = 2'd1,
    OP_RX_BYTE  = 2'd2,
    OP_RX_ERROR = 2'd3
  } op_t;

  localparam logic KIND_DISPLAY = 1'b0;
  localparam logic KIND_SERIAL  = 1'b1;

  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] ASCII_LOWER_L = 8'h6C;
  localparam logic [7:0] ASCII_UPPER_L = 8'h4C;
  localparam logic [7:0] ASCII_DASH    = 8'h2D;
  localparam logic [7:0] ASCII_NEWLINE = 8'h0A;

  localparam int MAX_WORDS = 6;
  localparam int COUNT_W = $clog2(MAX_WORDS + 1);

  typedef struct packed {
    logic       kind;
    logic [6:0] segments;
    logic       high_digit;
    logic [7:0] tx_byte;
  } out_word_t;

  // One burst of result words handed to the output queue.
  typedef struct packed {
    logic [COUNT_W-1:0]              count;
    out_word_t [MAX_WORDS-1:0]       words;
  } burst_t;

  // Tens digit for v < 69: (v*13) >> 7.
  function automatic logic [3:0] digit_tens(input logic [5:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'd13;
    return {1'b0, p[9:7]};
  endfunction

  function automatic logic [3:0] digit_units(input logic [5:0] v);
    logic [5:0] t;
    t = 6'(digit_tens(v)) * 6'd10;
    return 4'(v - t);
  endfunction

  function automatic logic [6:0] seg_pattern(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic out_word_t serial_word(input logic [7:0] b);
    out_word_t w;
    w.kind       = KIND_SERIAL;
    w.segments   = 7'd0;
    w.high_digit = 1'b0;
    w.tx_byte    = b;
    return w;
  endfunction

  function automatic out_word_t display_word(input logic [6:0] seg, input logic hi);
    out_word_t w;
    w.kind       = KIND_DISPLAY;
    w.segments   = seg;
    w.high_digit = hi;
    w.tx_byte    = 8'd0;
    return w;
  endfunction

  function automatic logic [7:0] ascii_digit(input logic [3:0] d);
    return ASCII_ZERO + 8'(d);
  endfunction

endpackage

`default_nettype wire

// ===== src/avmm_out_queue.sv =====
// Output word queue: holds one burst and sends it one word per handshake.
`timescale 1ns / 1ps
`default_nettype none
`include "averaging_voltmeter_with_min_max_core_macros.svh"

module avmm_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire avmm_pkg::burst_t burst,
  output logic                  free,
  output logic                  word_valid,
  input  wire logic             word_stall,
  output logic                  kind,
  output logic [6:0]            segments,
  output logic                  high_digit,
  output logic [7:0]            tx_byte,
  output logic                  last
);

  avmm_pkg::out_word_t [avmm_pkg::MAX_WORDS-1:0] words;
  logic [avmm_pkg::COUNT_W-1:0] count;
  logic emit;

  assign word_valid = (count != '0);
  assign emit       = word_valid && !word_stall;
  // free also when the final word leaves this cycle
  assign free       = (count == '0) || (emit && count == avmm_pkg::COUNT_W'(1));

  assign kind       = words[0].kind;
  assign segments   = words[0].segments;
  assign high_digit = words[0].high_digit;
  assign tx_byte    = words[0].tx_byte;
  assign last       = (count == avmm_pkg::COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.count;
    end else if (emit) begin
      count <= count - avmm_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= burst.words;
    end else if (emit) begin
      for (int i = 0; i < avmm_pkg::MAX_WORDS - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

  `AVMM_ASSERT_IMPL(a_load_when_free, load, free)
  `AVMM_ASSERT_IMPL(a_count_range, 1'b1, count <= avmm_pkg::COUNT_W'(avmm_pkg::MAX_WORDS))
  `AVMM_ASSERT_NEXT(a_drain_step, emit && count > avmm_pkg::COUNT_W'(1) && !load,
                    count == $past(count) - avmm_pkg::COUNT_W'(1))

endmodule

`default_nettype wire

// ===== src/averaging_voltmeter_with_min_max_core.sv =====
// Top level of the averaging two-digit voltmeter with running min and max.
`timescale 1ns / 1ps
`default_nettype none
`include "averaging_voltmeter_with_min_max_core_macros.svh"

// Usage
//   Input channel (item_valid / item_stall): op, sample, rx_byte. A word is
//   taken at a clock edge with item_valid high and item_stall low.
//   Output channel (word_valid / word_stall): kind, segments, high_digit,
//   tx_byte, last. An input word causes 0 to 6 output words; last marks the
//   final one. Samples and receive errors and other bytes produce none.
//   A word waits in the input register until the queue can take its burst;
//   the queue register then presents the first output word of that burst.
//   Throughput: one input word per cycle while the output queue can take the
//   burst; a burst of N words holds the queue until its last word is taken,
//   and the next word with output waits in the input register meanwhile.
//   Samples flow at one per cycle unless an earlier word is still waiting in
//   the input register for the queue.
//   Output stall simply freezes the queue head; the input register then fills
//   and item_stall rises.
//   Reset (rst, synchronous): empties both stages, report_period = 100,
//   lowest value = 33, all other state zero, tens digit shown first.
//   APB port: report_period at byte address 0, written on psel & penable &
//   pwrite; pready is tied high.

module averaging_voltmeter_with_min_max_core #(
  parameter int SAMPLES_PER_AVERAGE = avmm_pkg::SAMPLES_PER_AVERAGE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  op,
  input  wire logic [9:0]  sample,
  input  wire logic [7:0]  rx_byte,
  // output channel
  output logic             word_valid,
  input  wire logic        word_stall,
  output logic             kind,
  output logic [6:0]       segments,
  output logic             high_digit,
  output logic [7:0]       tx_byte,
  output logic             last,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Batch sum holds up to 33 per sample.
  localparam int SUM_W     = $clog2(33 * SAMPLES_PER_AVERAGE + 1);
  localparam int BATCH_W   = $clog2(SAMPLES_PER_AVERAGE);
  localparam int PROD_W    = SUM_W + avmm_pkg::DIV_SHIFT;
  // ceil(2^20 / N): error below 33*N / 2^20 < 1/N, so the quotient is exact.
  localparam int DIV_MULT  = ((1 << avmm_pkg::DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1)
                             / SAMPLES_PER_AVERAGE;
  localparam logic [BATCH_W-1:0] LAST_BATCH = BATCH_W'(SAMPLES_PER_AVERAGE - 1);

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [15:0] report_period;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == avmm_pkg::REG_REPORT_PERIOD) ? {16'd0, report_period}
                                                               : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_period <= avmm_pkg::REPORT_PERIOD_RESET;
    end else if (cfg_write && paddr[2] == avmm_pkg::REG_REPORT_PERIOD) begin
      report_period <= pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------------
  // Input register; the sample is scaled to tenths of a volt on the way in
  // ---------------------------------------------------------------------
  logic [31:0]   scale_prod;
  logic [5:0]    scaled_in;

  logic          in_reg_valid;
  avmm_pkg::op_t in_op;
  logic [5:0]    in_scaled;
  logic [7:0]    in_rx;

  logic          fire;

  assign scale_prod = 32'(sample) * avmm_pkg::SCALE_MULT + avmm_pkg::SCALE_ADD;
  assign scaled_in  = scale_prod[avmm_pkg::SCALE_SHIFT +: 6];

  assign item_stall = in_reg_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_reg_valid <= 1'b1;
    end else if (fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_op     <= avmm_pkg::op_t'(op);
      in_scaled <= scaled_in;
      in_rx     <= rx_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Voltmeter state
  // ---------------------------------------------------------------------
  logic [BATCH_W-1:0] batch_index;
  logic [SUM_W-1:0]   scaled_sum;
  logic [5:0]         current_volts;
  logic [5:0]         lowest_volts;
  logic [5:0]         highest_volts;
  logic               showing_units;
  logic [15:0]        tick_count;

  logic [SUM_W-1:0]   sum_next;
  logic [PROD_W-1:0]  avg_prod;
  logic [5:0]         avg;
  logic [15:0]        tick_next;
  logic               report_due;
  logic [3:0]         shown_digit;
  logic               is_list_cmd;

  avmm_pkg::burst_t   burst;
  logic               queue_free;

  assign sum_next   = scaled_sum + SUM_W'(in_scaled);
  assign avg_prod   = PROD_W'(sum_next) * PROD_W'(DIV_MULT);
  assign avg        = avg_prod[avmm_pkg::DIV_SHIFT +: 6];
  assign tick_next  = tick_count + 16'd1;
  assign report_due = (tick_next == report_period);
  assign shown_digit = showing_units ? avmm_pkg::digit_units(current_volts)
                                     : avmm_pkg::digit_tens(current_volts);
  assign is_list_cmd = (in_rx == avmm_pkg::ASCII_LOWER_L) ||
                       (in_rx == avmm_pkg::ASCII_UPPER_L);

  // Result burst for the word in the input register.
  always_comb begin
    burst.count = '0;
    burst.words = '0;
    unique case (in_op)
      avmm_pkg::OP_TICK: begin
        burst.words[0] = avmm_pkg::display_word(avmm_pkg::seg_pattern(shown_digit),
                                                !showing_units);
        burst.count    = avmm_pkg::COUNT_W'(1);
        if (report_due) begin
          burst.words[1] = avmm_pkg::serial_word(
                             avmm_pkg::ascii_digit(avmm_pkg::digit_tens(current_volts)));
          burst.words[2] = avmm_pkg::serial_word(
                             avmm_pkg::ascii_digit(avmm_pkg::digit_units(current_volts)));
          burst.words[3] = avmm_pkg::serial_word(avmm_pkg::ASCII_NEWLINE);
          burst.count    = avmm_pkg::COUNT_W'(4);
        end
      end
      avmm_pkg::OP_RX_BYTE: begin
        if (is_list_cmd) begin
          burst.words[0] = avmm_pkg::serial_word(
                             avmm_pkg::ascii_digit(avmm_pkg::digit_tens(lowest_volts)));
          burst.words[1] = avmm_pkg::serial_word(
                             avmm_pkg::ascii_digit(avmm_pkg::digit_units(lowest_volts)));
          burst.words[2] = avmm_pkg::serial_word(avmm_pkg::ASCII_DASH);
          burst.words[3] = avmm_pkg::serial_word(
                             avmm_pkg::ascii_digit(avmm_pkg::digit_tens(highest_volts)));
          burst.words[4] = avmm_pkg::serial_word(
                             avmm_pkg::ascii_digit(avmm_pkg::digit_units(highest_volts)));
          burst.words[5] = avmm_pkg::serial_word(avmm_pkg::ASCII_NEWLINE);
          burst.count    = avmm_pkg::COUNT_W'(6);
        end
      end
      avmm_pkg::OP_SAMPLE,
      avmm_pkg::OP_RX_ERROR: begin
        burst.count = '0;
      end
      default: begin
        burst.count = '0;
      end
    endcase
  end

  // Words with no output never wait on the queue.
  assign fire = in_reg_valid && ((burst.count == '0) || queue_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_index   <= '0;
      scaled_sum    <= '0;
      current_volts <= '0;
      lowest_volts  <= avmm_pkg::FULL_SCALE;
      highest_volts <= '0;
      showing_units <= 1'b0;
      tick_count    <= '0;
    end else if (fire) begin
      unique case (in_op)
        avmm_pkg::OP_SAMPLE: begin
          if (batch_index == LAST_BATCH) begin
            current_volts <= avg;
            if (avg > highest_volts) highest_volts <= avg;
            if (avg < lowest_volts)  lowest_volts  <= avg;
            scaled_sum  <= '0;
            batch_index <= '0;
          end else begin
            scaled_sum  <= sum_next;
            batch_index <= batch_index + BATCH_W'(1);
          end
        end
        avmm_pkg::OP_TICK: begin
          showing_units <= !showing_units;
          tick_count    <= report_due ? 16'd0 : tick_next;
        end
        avmm_pkg::OP_RX_BYTE,
        avmm_pkg::OP_RX_ERROR: begin
          tick_count <= tick_count;
        end
        default: begin
          tick_count <= tick_count;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  avmm_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (fire && burst.count != '0),
    .burst      (burst),
    .free       (queue_free),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .kind       (kind),
    .segments   (segments),
    .high_digit (high_digit),
    .tx_byte    (tx_byte),
    .last       (last)
  );

  `AVMM_ASSERT_IMPL(a_no_stall_when_empty, !in_reg_valid, !item_stall)
  `AVMM_ASSERT_IMPL(a_volts_in_range, 1'b1,
                    current_volts <= avmm_pkg::FULL_SCALE && lowest_volts <= avmm_pkg::FULL_SCALE)
  `AVMM_ASSERT_NEXT(a_batch_wraps, fire && in_op == avmm_pkg::OP_SAMPLE && batch_index == LAST_BATCH,
                    batch_index == '0 && scaled_sum == '0)

endmodule

`default_nettype wire

// ===== sim/tb_averaging_voltmeter_with_min_max_core.sv =====
// Testbench for the averaging voltmeter core: queued stimulus, readout predictor, word checker.
`timescale 1ns / 1ps

module tb_averaging_voltmeter_with_min_max_core;

  // Timing knobs. A word passes the input register and then the output queue, so
  // extra settle cycles cover a trailing sample still sitting in the input stage.
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT    = 2000;

  // Receiver stall patterns.
  localparam int STALL_NONE   = 0;
  localparam int STALL_COIN   = 1;
  localparam int STALL_CADENT = 2;
  localparam int STALL_LONG   = 3;

  localparam logic [2:0] PERIOD_ADDR = {avmm_pkg::REG_REPORT_PERIOD, 2'b00};

  // Digit glyphs 9..0, seven bits each, segment a in bit 0.
  localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                    7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef struct packed {
    avmm_pkg::op_t code;
    logic [9:0]    smp;
    logic [7:0]    rxb;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] segments;
    logic       high_digit;
    logic [7:0] tx_byte;
    logic       last;
  } readout_t;

  logic          clk;
  logic          rst = 1'b1;

  logic          item_valid = 1'b0;
  logic          item_stall;
  avmm_pkg::op_t item_op = avmm_pkg::OP_SAMPLE;
  logic [9:0]    item_sample = '0;
  logic [7:0]    item_rx = '0;

  logic          word_valid;
  logic          word_stall = 1'b0;
  logic          kind;
  logic [6:0]    segments;
  logic          high_digit;
  logic [7:0]    tx_byte;
  logic          last;

  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  averaging_voltmeter_with_min_max_core uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (item_op),
    .sample     (item_sample),
    .rx_byte    (item_rx),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .kind       (kind),
    .segments   (segments),
    .high_digit (high_digit),
    .tx_byte    (tx_byte),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Words waiting to be driven, and readout words waiting to come back.
  item_t    queued_items[$];
  readout_t readout_q[$];
  int       mismatches = 0;

  // Predictor state, mirrors the meter's own registers.
  int          acc_count = 0;
  logic [8:0]  acc_sum = '0;
  logic [5:0]  volts_now = '0;
  logic [5:0]  volts_low = avmm_pkg::FULL_SCALE;
  logic [5:0]  volts_high = '0;
  logic        units_next = 1'b0;
  logic [15:0] tick_total = '0;
  logic [15:0] period_cfg = avmm_pkg::REPORT_PERIOD_RESET;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches = mismatches + 1;
  endtask

  task automatic push_serial(input logic [7:0] b);
    readout_q.push_back('{kind: avmm_pkg::KIND_SERIAL, segments: 7'd0, high_digit: 1'b0,
                          tx_byte: b, last: 1'b0});
  endtask

  task automatic push_digit_pair(input logic [5:0] v);
    push_serial(avmm_pkg::ASCII_ZERO + 8'(v / 6'd10));
    push_serial(avmm_pkg::ASCII_ZERO + 8'(v % 6'd10));
  endtask

  // Works out the readout words that one accepted input word causes.
  task automatic predict_readout(input avmm_pkg::op_t code, input logic [9:0] smp,
                                 input logic [7:0] rxb);
    int         scaled;
    int         first;
    logic [5:0] digit;
    first = readout_q.size();
    case (code)
      avmm_pkg::OP_SAMPLE: begin
        // rounding scale to tenths of a volt, then batch average
        scaled = (int'(smp) * 33 + 511) / 1023;
        acc_sum = acc_sum + 9'(scaled);
        acc_count = acc_count + 1;
        if (acc_count >= avmm_pkg::SAMPLES_PER_AVERAGE) begin
          volts_now = 6'(acc_sum / avmm_pkg::SAMPLES_PER_AVERAGE);
          if (volts_now > volts_high) volts_high = volts_now;
          if (volts_now < volts_low) volts_low = volts_now;
          acc_sum = '0;
          acc_count = 0;
        end
      end
      avmm_pkg::OP_TICK: begin
        digit = units_next ? volts_now % 6'd10 : volts_now / 6'd10;
        readout_q.push_back('{kind: avmm_pkg::KIND_DISPLAY, segments: GLYPHS[digit * 7 +: 7],
                              high_digit: !units_next, tx_byte: 8'd0, last: 1'b0});
        units_next = !units_next;
        // counter wraps at 16 bits; a period below the count waits for the wrap
        tick_total = tick_total + 16'd1;
        if (tick_total == period_cfg) begin
          push_digit_pair(volts_now);
          push_serial(avmm_pkg::ASCII_NEWLINE);
          tick_total = '0;
        end
      end
      avmm_pkg::OP_RX_BYTE: begin
        if (rxb == avmm_pkg::ASCII_LOWER_L || rxb == avmm_pkg::ASCII_UPPER_L) begin
          push_digit_pair(volts_low);
          push_serial(avmm_pkg::ASCII_DASH);
          push_digit_pair(volts_high);
          push_serial(avmm_pkg::ASCII_NEWLINE);
        end
      end
      default: ; // receive error: byte dropped
    endcase
    if (readout_q.size() > first) readout_q[readout_q.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks output words against the oldest prediction, then predicts
  // for any input word taken on the same edge.
  // ---------------------------------------------------------------------------
  logic item_taken = 1'b0;

  always @(posedge clk) begin : monitor
    readout_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && !item_stall;
      if (word_valid && !word_stall) begin
        if (readout_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word kind %0b seg %h tx %h",
                                  kind, segments, tx_byte));
        end else begin
          want = readout_q.pop_front();
          if (kind !== want.kind)
            flag_mismatch($sformatf("kind %0b, want %0b", kind, want.kind));
          if (segments !== want.segments)
            flag_mismatch($sformatf("segments %h, want %h", segments, want.segments));
          if (high_digit !== want.high_digit)
            flag_mismatch($sformatf("high_digit %0b, want %0b", high_digit,
                                    want.high_digit));
          if (tx_byte !== want.tx_byte)
            flag_mismatch($sformatf("tx_byte %h, want %h", tx_byte, want.tx_byte));
          if (last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
        end
      end
      if (item_valid && !item_stall) predict_readout(item_op, item_sample, item_rx);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of words from the queue with random gaps; a word holds
  // until the edge that takes it.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin : feeder
    item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        item_valid <= 1'b0;
      end else if (queued_items.size() != 0) begin
        nxt = queued_items.pop_front();
        item_valid <= 1'b1;
        item_op <= nxt.code;
        item_sample <= nxt.smp;
        item_rx <= nxt.rxb;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          // a third of the bursts run straight into the next one
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is redrawn at random, periodically, from four modes.
  int rx_cycle = 0;
  int stall_mode = STALL_NONE;
  int stall_run = 0;

  always @(negedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (rx_cycle % 89 == 0) stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
    case (stall_mode)
      STALL_NONE:   word_stall <= 1'b0;
      STALL_COIN:   word_stall <= ($urandom_range(0, 1) == 1);
      STALL_CADENT: word_stall <= (rx_cycle % 5 < 2);
      default: begin
        if (stall_run > 0) stall_run = stall_run - 1;
        else if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
        word_stall <= (stall_run > 0);
      end
    endcase
  end

  // Watchdog: too long without any word moving on either side.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (word_valid && !word_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input avmm_pkg::op_t c, input logic [9:0] s,
                           input logic [7:0] r);
    queued_items.push_back('{code: c, smp: s, rxb: r});
  endtask

  // Sender holds off until every predicted word is back, then a little longer.
  task automatic settle();
    while (queued_items.size() != 0 || item_valid || readout_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write report_period, then read it back.
  task automatic set_report_period(input logic [15:0] val);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PERIOD_ADDR;
    pwdata <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    period_cfg = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[15:0] !== val)
      flag_mismatch($sformatf("report_period read %h, want %h", got[15:0], val));
  endtask

  // Random mix; about a third are whole batches around one level so that the
  // average, min and max move over the full range.
  task automatic queue_random(input int count);
    int added;
    int pick;
    int level;
    int s;
    int k;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: begin
          level = $urandom_range(0, 1023);
          for (k = 0; k < avmm_pkg::SAMPLES_PER_AVERAGE; k++) begin
            s = level + int'($urandom_range(0, 80)) - 40;
            if (s < 0) s = 0;
            if (s > 1023) s = 1023;
            push_item(avmm_pkg::OP_SAMPLE, 10'(s), 8'($urandom_range(0, 255)));
          end
          added = added + avmm_pkg::SAMPLES_PER_AVERAGE;
        end
        3: begin
          push_item(avmm_pkg::OP_SAMPLE, 10'($urandom_range(0, 1023)),
                    8'($urandom_range(0, 255)));
          added = added + 1;
        end
        4, 5: begin
          push_item(avmm_pkg::OP_TICK, 10'($urandom_range(0, 1023)),
                    8'($urandom_range(0, 255)));
          added = added + 1;
        end
        6: begin
          push_item(avmm_pkg::OP_RX_BYTE, 10'($urandom_range(0, 1023)),
                    ($urandom_range(0, 1) == 1) ? avmm_pkg::ASCII_LOWER_L
                                                : avmm_pkg::ASCII_UPPER_L);
          added = added + 1;
        end
        7: begin
          push_item(avmm_pkg::OP_RX_BYTE, 10'($urandom_range(0, 1023)),
                    8'($urandom_range(0, 255)));
          added = added + 1;
        end
        default: begin
          push_item(avmm_pkg::OP_RX_ERROR, 10'($urandom_range(0, 1023)),
                    ($urandom_range(0, 1) == 1) ? avmm_pkg::ASCII_LOWER_L
                                                : 8'($urandom_range(0, 255)));
          added = added + 1;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset min/max report, both digits of zero, dropped and
    // ignored bytes, rounding edge of the scale, full-scale batch.
    push_item(avmm_pkg::OP_RX_BYTE, 10'd0, avmm_pkg::ASCII_LOWER_L);
    push_item(avmm_pkg::OP_TICK, 10'd0, 8'd0);
    push_item(avmm_pkg::OP_TICK, 10'd1023, 8'd255);
    push_item(avmm_pkg::OP_RX_ERROR, 10'd0, avmm_pkg::ASCII_UPPER_L);
    push_item(avmm_pkg::OP_RX_BYTE, 10'd0, 8'h00);
    push_item(avmm_pkg::OP_RX_BYTE, 10'd1023, 8'hFF);
    push_item(avmm_pkg::OP_SAMPLE, 10'd0, 8'd0);
    push_item(avmm_pkg::OP_SAMPLE, 10'd15, 8'd0);
    push_item(avmm_pkg::OP_SAMPLE, 10'd16, 8'd0);
    for (k = 0; k < avmm_pkg::SAMPLES_PER_AVERAGE - 3; k++)
      push_item(avmm_pkg::OP_SAMPLE, 10'd1023, 8'd0);
    push_item(avmm_pkg::OP_TICK, 10'd0, 8'd0);
    push_item(avmm_pkg::OP_TICK, 10'd0, 8'd0);
    push_item(avmm_pkg::OP_RX_BYTE, 10'd0, avmm_pkg::ASCII_UPPER_L);
    for (k = 0; k < avmm_pkg::SAMPLES_PER_AVERAGE; k++)
      push_item(avmm_pkg::OP_SAMPLE, 10'd1023, 8'd0);
    push_item(avmm_pkg::OP_RX_BYTE, 10'd0, avmm_pkg::ASCII_LOWER_L);
    settle();

    // Largest period stays silent; then a period under the count stays
    // silent too; then a period just ahead of the count brings it back to 0.
    set_report_period(16'hFFFF);
    repeat (24) push_item(avmm_pkg::OP_TICK, 10'($urandom_range(0, 1023)), 8'd0);
    settle();
    set_report_period(16'd5);
    repeat (12) push_item(avmm_pkg::OP_TICK, 10'd0, 8'($urandom_range(0, 255)));
    settle();
    set_report_period(tick_total + 16'd8);
    repeat (8) push_item(avmm_pkg::OP_TICK, 10'd0, 8'd0);
    settle();

    // Random phases, smallest period first.
    set_report_period(16'd1);
    queue_random(100);
    settle();
    set_report_period(16'd3);
    queue_random(110);
    settle();
    set_report_period(16'd7);
    queue_random(110);
    settle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
